### rtl/nf3_pkg.sv
// Shared constants, types and arithmetic helpers for the 3x3 RGB neighborhood filter.
package nf3_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;
   localparam int CHANNELS   = 3;
   localparam int ADDR_W     = $clog2(MAX_WIDTH);
   localparam int POS_W      = 11;
   localparam int GEOM_W     = 12;
   localparam int DIVN_W     = 18;
   localparam int DIVD_W     = 8;

   // floor(x / 25) == (x * RECIP_25) >> RECIP_SHIFT for any 15-bit x
   localparam logic [18:0] RECIP_25    = 19'd335545;
   localparam int          RECIP_SHIFT = 23;

   localparam logic [1:0] MODE_EDGE    = 2'd0;
   localparam logic [1:0] MODE_SHARPEN = 2'd1;
   localparam logic [1:0] MODE_SOFTEN  = 2'd2;
   localparam logic [1:0] MODE_EMBOSS  = 2'd3;

   localparam logic [1:0] REG_MODE     = 2'd0;
   localparam logic [1:0] REG_STRENGTH = 2'd1;
   localparam logic [1:0] REG_WIDTH    = 2'd2;
   localparam logic [1:0] REG_HEIGHT   = 2'd3;

   typedef logic [23:0] pixel_type;
   typedef logic [2*24-1:0] line_word_type;

   typedef struct packed {
      logic              start;
      logic [DIVN_W-1:0] dividend;
      logic [DIVD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVN_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [7:0] px_chan(input pixel_type px, input logic [1:0] ch);
      logic [7:0] v;
      case (ch)
         2'd0:    v = px[7:0];
         2'd1:    v = px[15:8];
         default: v = px[23:16];
      endcase
      return v;
   endfunction

   function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [7:0] clamp_u8(input logic signed [11:0] k);
      logic [7:0] v;
      if (k < 0) v = 8'd0;
      else if (k > 12'sd255) v = 8'd255;
      else v = k[7:0];
      return v;
   endfunction

endpackage

### rtl/nf3_line_mem.sv
// Line buffer memory: two previous rows packed per column, registered read.
module nf3_line_mem
   import nf3_pkg::*;
(
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output line_word_type     rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  line_word_type     wr_data
);

   line_word_type mem [MAX_WIDTH];
   line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/nf3_divider.sv
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
module nf3_divider
   import nf3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CNT_W = $clog2(DIVN_W + 1);

   logic [DIVN_W-1:0] quo_ff, quo_in;
   logic [DIVD_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVD_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIVN_W-1]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         cnt_in  = CNT_W'(DIVN_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIVD_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIVN_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVD_W-1:0];
            quo_in = {quo_ff[DIVN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

### rtl/neighbourhood_filter_3x3_rgb.sv
// Top level of the 3x3 RGB neighborhood filter: control, window and filter arithmetic.
// Streaming 3x3 filter (edge, sharpen, soften, emboss) on raster RGB pixels, with
// borders reflected and results clamped to 0..255. One pixel is taken at a time:
// the line buffer is read and written back, then each result is worked out in three
// channel passes, directly for edge and emboss, by reciprocal multiplication for
// sharpen and by the bit-serial divider for soften, and is handed out before the
// next one starts. A pixel causes 0, 1, 2 or 4 results; results lag one row and one
// column, and the last row comes out interleaved with row H-2. Writing the width or
// height restarts the image.
module neighbourhood_filter_3x3_rgb
   import nf3_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_red_in,
   input  logic [7:0]       req_green_in,
   input  logic [7:0]       req_blue_in,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic [POS_W-1:0] rsp_out_col,
   output logic [POS_W-1:0] rsp_out_row,
   output logic             rsp_last_of_run,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [11:0]      csr_data
);

   typedef enum logic [2:0] {S_IDLE, S_READ, S_CALC, S_DIV, S_OUT} state_type;

   state_type state_ff, state_in;

   logic [1:0]        mode_ff, mode_in;
   logic [6:0]        strength_ff, strength_in;
   logic [GEOM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [POS_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic [POS_W-1:0]  cur_c_ff, cur_c_in, cur_r_ff, cur_r_in;
   pixel_type         pix_ff, pix_in;
   pixel_type         win_ff [9];
   pixel_type         win_in [9];
   logic [3:0]        pend_ff, pend_in;
   logic [1:0]        ch_ff, ch_in;
   logic              neg_ff, neg_in;
   logic [14:0]       rnum_ff, rnum_in;
   logic [7:0]        out_ff [CHANNELS];
   logic [7:0]        out_in [CHANNELS];
   logic              rsp_valid_ff, rsp_valid_in;

   logic [GEOM_W-1:0] w_eff, h_eff;
   logic [POS_W-1:0]  c_eff, r_eff;
   logic              accept;
   line_word_type     mem_rdata, mem_wdata;
   logic              mem_wr;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic [1:0]        sel;
   logic [3:0]        sel_mask;
   logic              bottom;
   logic [1:0]        wcol, crow, uprow, downrow, lc, rc;
   logic [POS_W-1:0]  x_pos, y_pos;
   logic [7:0]        cv, uv, dv, lv, rv, ulv, urv;
   logic [6:0]        s_sat;
   logic signed [11:0] lap;
   logic [9:0]        edge_sum, emb_sum;
   logic signed [11:0] k_direct;
   logic [15:0]       c200;
   logic signed [19:0] prod, num;
   logic [19:0]       num_mag;
   logic [33:0]       recip_prod;
   logic [10:0]       quot;
   logic signed [11:0] sq, k_div;
   logic              last_row;
   logic [GEOM_W-1:0] c_next, r_next;

   assign w_eff = (width_ff < GEOM_W'(2)) ? GEOM_W'(2) :
                  (width_ff > GEOM_W'(MAX_WIDTH)) ? GEOM_W'(MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff < GEOM_W'(2)) ? GEOM_W'(2) :
                  (height_ff > GEOM_W'(MAX_HEIGHT)) ? GEOM_W'(MAX_HEIGHT) : height_ff;
   assign c_eff = ({1'b0, col_ff} >= w_eff) ? '0 : col_ff;
   assign r_eff = ({1'b0, row_ff} >= h_eff) ? '0 : row_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   nf3_line_mem u_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (ADDR_W'(c_eff)),
      .rd_data (mem_rdata),
      .wr_en   (mem_wr),
      .wr_addr (ADDR_W'(cur_c_ff)),
      .wr_data (mem_wdata)
   );

   nf3_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // current result and its neighbor columns
   always_comb begin
      sel = 2'd0;
      if (pend_ff[0]) sel = 2'd0;
      else if (pend_ff[1]) sel = 2'd1;
      else if (pend_ff[2]) sel = 2'd2;
      else sel = 2'd3;
      sel_mask = 4'b0001 << sel;
      bottom   = sel[0];
      wcol     = sel[1] ? 2'd2 : 2'd1;
      crow     = bottom ? 2'd2 : 2'd1;
      uprow    = bottom ? 2'd1 : ((cur_r_ff == POS_W'(1)) ? 2'd2 : 2'd0);
      downrow  = bottom ? 2'd1 : 2'd2;
      x_pos    = sel[1] ? cur_c_ff : cur_c_ff - 1'b1;
      y_pos    = bottom ? cur_r_ff : cur_r_ff - 1'b1;
      lc = (x_pos == '0) ? wcol + 2'd1 : wcol - 2'd1;
      rc = ({1'b0, x_pos} + GEOM_W'(1) >= w_eff) ? wcol - 2'd1 : wcol + 2'd1;
      if (lc > 2'd2) lc = 2'd1;
      if (rc > 2'd2) rc = 2'd1;
      cv  = px_chan(win_ff[4'(crow) * 4'd3 + 4'(wcol)], ch_ff);
      uv  = px_chan(win_ff[4'(uprow) * 4'd3 + 4'(wcol)], ch_ff);
      dv  = px_chan(win_ff[4'(downrow) * 4'd3 + 4'(wcol)], ch_ff);
      lv  = px_chan(win_ff[4'(crow) * 4'd3 + 4'(lc)], ch_ff);
      rv  = px_chan(win_ff[4'(crow) * 4'd3 + 4'(rc)], ch_ff);
      ulv = px_chan(win_ff[4'(uprow) * 4'd3 + 4'(lc)], ch_ff);
      urv = px_chan(win_ff[4'(uprow) * 4'd3 + 4'(rc)], ch_ff);
   end

   // per channel arithmetic
   always_comb begin
      s_sat    = (strength_ff > 7'd100) ? 7'd100 : strength_ff;
      lap      = $signed(12'(uv) + 12'(dv) + 12'(lv) + 12'(rv) - {2'b00, cv, 2'b00});
      edge_sum = 10'(abs_diff(cv, uv)) + 10'(abs_diff(cv, dv))
               + 10'(abs_diff(cv, lv)) + 10'(abs_diff(cv, rv));
      emb_sum  = 10'(uv) + 10'(lv) + 10'(ulv) + 10'(urv);
      if (mode_ff == MODE_EDGE) begin
         k_direct = $signed(12'(edge_sum) + 12'(edge_sum[9:1]));
      end else begin
         k_direct = $signed(12'(emb_sum[9:2]) - 12'(cv) + 12'd127);
      end
      c200 = 16'(cv) * 16'd200;
      prod = $signed({1'b0, s_sat}) * lap;
      if (mode_ff == MODE_SHARPEN) begin
         num = $signed({4'b0000, c200}) - prod;
      end else begin
         num = 20'(lap) * 20'sd5;
      end
      num_mag = num[19] ? 20'(-num) : num;
      // |num| / 200 as (|num| >> 3) / 25 by reciprocal multiplication
      recip_prod = {19'd0, rnum_ff} * {15'd0, RECIP_25};
      quot    = (mode_ff == MODE_SHARPEN) ? recip_prod[RECIP_SHIFT +: 11]
                                          : div_rsp.quotient[10:0];
      sq      = neg_ff ? 12'(-$signed({1'b0, quot})) : $signed({1'b0, quot});
      k_div   = (mode_ff == MODE_SOFTEN) ? 12'(cv) + sq : sq;
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      strength_in  = strength_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cur_c_in     = cur_c_ff;
      cur_r_in     = cur_r_ff;
      pix_in       = pix_ff;
      win_in       = win_ff;
      pend_in      = pend_ff;
      ch_in        = ch_ff;
      neg_in       = neg_ff;
      rnum_in      = rnum_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_wr       = 1'b0;
      mem_wdata    = {mem_rdata[23:0], pix_ff};
      div_req.start    = 1'b0;
      div_req.dividend = num_mag[DIVN_W-1:0];
      div_req.divisor  = 8'(7'd125 - s_sat);
      last_row = ({1'b0, cur_r_ff} + GEOM_W'(1) == h_eff);
      c_next   = {1'b0, cur_c_ff} + GEOM_W'(1);
      r_next   = {1'b0, cur_r_ff} + GEOM_W'(1);

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cur_c_in = c_eff;
               cur_r_in = r_eff;
               pix_in   = {req_blue_in, req_green_in, req_red_in};
               state_in = S_READ;
            end
         end
         S_READ: begin
            for (int i = 0; i < 3; i++) begin
               win_in[i*3]   = win_ff[i*3+1];
               win_in[i*3+1] = win_ff[i*3+2];
            end
            win_in[2] = mem_rdata[47:24];
            win_in[5] = mem_rdata[23:0];
            win_in[8] = pix_ff;
            mem_wr    = 1'b1;
            pend_in   = '0;
            if (cur_r_ff != '0) begin
               pend_in[0] = (cur_c_ff != '0);
               pend_in[1] = (cur_c_ff != '0) && last_row;
               pend_in[2] = (c_next == w_eff);
               pend_in[3] = (c_next == w_eff) && last_row;
            end
            if (c_next >= w_eff) begin
               col_in = '0;
               row_in = (r_next >= h_eff) ? '0 : POS_W'(r_next);
            end else begin
               col_in = POS_W'(c_next);
               row_in = cur_r_ff;
            end
            ch_in    = 2'd0;
            state_in = (pend_in != '0) ? S_CALC : S_IDLE;
         end
         S_CALC: begin
            if (mode_ff == MODE_SHARPEN || mode_ff == MODE_SOFTEN) begin
               div_req.start = (mode_ff == MODE_SOFTEN);
               neg_in        = num[19];
               rnum_in       = num_mag[17:3];
               state_in      = S_DIV;
            end else begin
               out_in[ch_ff] = clamp_u8(k_direct);
               if (ch_ff == 2'(CHANNELS - 1)) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_OUT;
               end else begin
                  ch_in = ch_ff + 2'd1;
               end
            end
         end
         S_DIV: begin
            if (mode_ff == MODE_SHARPEN || div_rsp.done) begin
               out_in[ch_ff] = clamp_u8(k_div);
               if (ch_ff == 2'(CHANNELS - 1)) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_OUT;
               end else begin
                  ch_in    = ch_ff + 2'd1;
                  state_in = S_CALC;
               end
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               pend_in      = pend_ff & ~sel_mask;
               ch_in        = 2'd0;
               state_in     = (pend_in == '0) ? S_IDLE : S_CALC;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MODE:     mode_in     = csr_data[1:0];
            REG_STRENGTH: strength_in = csr_data[6:0];
            REG_WIDTH: begin
               width_in = csr_data;
               col_in   = '0;
               row_in   = '0;
            end
            REG_HEIGHT: begin
               height_in = csr_data;
               col_in    = '0;
               row_in    = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_EDGE;
         strength_ff  <= '0;
         width_ff     <= GEOM_W'(640);
         height_ff    <= GEOM_W'(480);
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= '0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         strength_ff  <= strength_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_ff      <= pend_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
      cur_c_ff <= cur_c_in;
      cur_r_ff <= cur_r_in;
      pix_ff   <= pix_in;
      neg_ff   <= neg_in;
      rnum_ff  <= rnum_in;
      out_ff   <= out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_out     = out_ff[0];
   assign rsp_green_out   = out_ff[1];
   assign rsp_blue_out    = out_ff[2];
   assign rsp_out_col     = x_pos;
   assign rsp_out_row     = y_pos;
   assign rsp_last_of_run = ((pend_ff & ~sel_mask) == '0);

endmodule

### tb/neighbourhood_filter_3x3_rgb_test.sv
// Self-checking testbench for the 3x3 RGB neighborhood filter with a built-in predictor.
`timescale 1ns / 1ps
module neighbourhood_filter_3x3_rgb_test
   import nf3_pkg::*;
();

   typedef struct {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
   } rgb_type;

   typedef struct {
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic             last;
   } filtered_px_type;

   logic             clock = 0;
   logic             reset = 1;
   logic             req_valid = 0;
   logic             req_ready;
   logic [7:0]       req_red_in = 0;
   logic [7:0]       req_green_in = 0;
   logic [7:0]       req_blue_in = 0;
   logic             rsp_valid;
   logic             rsp_ready = 0;
   logic [7:0]       rsp_red_out;
   logic [7:0]       rsp_green_out;
   logic [7:0]       rsp_blue_out;
   logic [POS_W-1:0] rsp_out_col;
   logic [POS_W-1:0] rsp_out_row;
   logic             rsp_last_of_run;
   logic             csr_valid = 0;
   logic             csr_ready;
   logic [1:0]       csr_index = 0;
   logic [11:0]      csr_data = 0;

   neighbourhood_filter_3x3_rgb dut (.*);

   always #5 clock = ~clock;

   rgb_type         pixel_q[$];
   filtered_px_type filtered_q[$];
   int           errors = 0;
   bit           quiet = 0;
   int           hold_seq = 0;
   int           hold_seen = 0;
   int           hold_cnt = 0;
   int           send_gap = 0;
   int           recv_gap = 0;
   int           idle_cycles = 0;

   // mirror of the block's state
   logic [1:0]  mode_m;
   logic [6:0]  strength_m;
   logic [11:0] width_m;
   logic [11:0] height_m;
   logic [23:0] line_two_m[MAX_WIDTH];
   logic [23:0] line_one_m[MAX_WIDTH];
   logic [23:0] window_m[9];
   int          col_m;
   int          row_m;

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (quiet || p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int chan_filter(int c, int u, int d, int l, int r, int ul, int ur);
      int s, lap, k;
      s = (strength_m > 100) ? 100 : strength_m;
      lap = u + d + l + r - 4 * c;
      case (mode_m)
         MODE_EDGE: begin
            k = (c > u ? c - u : u - c) + (c > d ? c - d : d - c)
                + (c > l ? c - l : l - c) + (c > r ? c - r : r - c);
            k = k + k / 2;
         end
         MODE_SHARPEN: k = (200 * c - s * lap) / 200;
         MODE_SOFTEN:  k = c + (5 * lap) / (125 - s);
         default:      k = (u + l + ul + ur) / 4 - c + 127;
      endcase
      if (k < 0) k = 0;
      if (k > 255) k = 255;
      return k;
   endfunction

   function automatic filtered_px_type filter_at(int crow, int uprow, int downrow, int wcol,
                                                 int x, int y, int w);
      filtered_px_type o;
      int lc, rc;
      int v[3];
      lc = (x == 0) ? wcol + 1 : wcol - 1;
      rc = (x + 1 >= w) ? wcol - 1 : wcol + 1;
      if (lc < 0 || lc > 2) lc = 1;
      if (rc < 0 || rc > 2) rc = 1;
      for (int ch = 0; ch < 3; ch++) begin
         v[ch] = chan_filter(window_m[crow*3+wcol][8*ch +: 8],
                             window_m[uprow*3+wcol][8*ch +: 8],
                             window_m[downrow*3+wcol][8*ch +: 8],
                             window_m[crow*3+lc][8*ch +: 8],
                             window_m[crow*3+rc][8*ch +: 8],
                             window_m[uprow*3+lc][8*ch +: 8],
                             window_m[uprow*3+rc][8*ch +: 8]);
      end
      o.red = 8'(v[0]); o.green = 8'(v[1]); o.blue = 8'(v[2]);
      o.col = POS_W'(x); o.row = POS_W'(y); o.last = 0;
      return o;
   endfunction

   task automatic predict_pixel(input logic [23:0] px);
      int w, h, c, r, up, first;
      logic [23:0] top, mid;
      w = (width_m < 2) ? 2 : (width_m > MAX_WIDTH) ? MAX_WIDTH : width_m;
      h = (height_m < 2) ? 2 : (height_m > MAX_HEIGHT) ? MAX_HEIGHT : height_m;
      if (col_m >= w) col_m = 0;
      if (row_m >= h) row_m = 0;
      c = col_m; r = row_m;
      top = line_two_m[c]; mid = line_one_m[c];
      for (int i = 0; i < 3; i++) begin
         window_m[i*3] = window_m[i*3+1];
         window_m[i*3+1] = window_m[i*3+2];
      end
      window_m[2] = top; window_m[5] = mid; window_m[8] = px;
      line_two_m[c] = mid;
      line_one_m[c] = px;
      first = filtered_q.size();
      if (r >= 1) begin
         up = (r == 1) ? 2 : 0;
         if (c >= 1) begin
            filtered_q.push_back(filter_at(1, up, 2, 1, c - 1, r - 1, w));
            if (r + 1 == h) filtered_q.push_back(filter_at(2, 1, 1, 1, c - 1, r, w));
         end
         if (c + 1 == w) begin
            filtered_q.push_back(filter_at(1, up, 2, 2, c, r - 1, w));
            if (r + 1 == h) filtered_q.push_back(filter_at(2, 1, 1, 2, c, r, w));
         end
      end
      if (filtered_q.size() > first) filtered_q[filtered_q.size()-1].last = 1;
      c++;
      if (c >= w) begin
         c = 0; r++;
         if (r >= h) r = 0;
      end
      col_m = c; row_m = r;
   endtask

   // monitor and predictor
   always @(posedge clock) begin
      filtered_px_type e;
      if (reset) begin
         mode_m <= MODE_EDGE; strength_m <= 0; width_m <= 640; height_m <= 480;
         col_m <= 0; row_m <= 0;
         for (int i = 0; i < 9; i++) window_m[i] <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MODE:     mode_m = csr_data[1:0];
               REG_STRENGTH: strength_m = csr_data[6:0];
               REG_WIDTH:    begin width_m = csr_data; col_m = 0; row_m = 0; end
               default:      begin height_m = csr_data; col_m = 0; row_m = 0; end
            endcase
         end
         if (req_valid && req_ready)
            predict_pixel({req_blue_in, req_green_in, req_red_in});
         if (rsp_valid && rsp_ready) begin
            if (filtered_q.size() == 0) begin
               $error("unexpected result at row %0d col %0d", rsp_out_row, rsp_out_col);
               errors++;
            end else begin
               e = filtered_q.pop_front();
               if (rsp_red_out !== e.red) begin
                  $error("red_out expected %0d actual %0d", e.red, rsp_red_out); errors++;
               end
               if (rsp_green_out !== e.green) begin
                  $error("green_out expected %0d actual %0d", e.green, rsp_green_out); errors++;
               end
               if (rsp_blue_out !== e.blue) begin
                  $error("blue_out expected %0d actual %0d", e.blue, rsp_blue_out); errors++;
               end
               if (rsp_out_col !== e.col) begin
                  $error("out_col expected %0d actual %0d", e.col, rsp_out_col); errors++;
               end
               if (rsp_out_row !== e.row) begin
                  $error("out_row expected %0d actual %0d", e.row, rsp_out_row); errors++;
               end
               if (rsp_last_of_run !== e.last) begin
                  $error("last_of_run expected %0d actual %0d", e.last, rsp_last_of_run);
                  errors++;
               end
            end
         end
      end
   end

   // pixel driver
   always @(posedge clock) begin
      rgb_type px;
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_ready) begin
      end else if (send_gap > 0) begin
         req_valid <= 0;
         send_gap <= send_gap - 1;
      end else if (pixel_q.size() > 0) begin
         px = pixel_q.pop_front();
         req_valid <= 1;
         req_red_in <= px.red;
         req_green_in <= px.green;
         req_blue_in <= px.blue;
         send_gap <= pick_gap();
      end else begin
         req_valid <= 0;
      end
   end

   // result sink
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_seen != hold_seq) begin
         hold_seen <= hold_seq;
         hold_cnt <= 400;
         rsp_ready <= 0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_ready <= 0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
         if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pixel_q.size() != 0 || req_valid || filtered_q.size() != 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic push_px(input int r, input int g, input int b);
      rgb_type px;
      px.red = 8'(r); px.green = 8'(g); px.blue = 8'(b);
      pixel_q.push_back(px);
   endtask

   task automatic push_random(input int n);
      for (int i = 0; i < n; i++)
         push_px($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   task automatic setup(input logic [1:0] m, input int s, input int w, input int h);
      wait_drained();
      write_reg(REG_MODE, 12'(m));
      write_reg(REG_STRENGTH, 12'(s));
      write_reg(REG_WIDTH, 12'(w));
      write_reg(REG_HEIGHT, 12'(h));
   endtask

   initial begin
      int sent, n, w, h, phase;
      repeat (2) @(posedge clock);
      reset <= 0;

      setup(MODE_EDGE, 0, 2, 2);
      push_px(0, 0, 0); push_px(255, 255, 255); push_px(255, 0, 255); push_px(0, 255, 0);
      setup(MODE_SHARPEN, 100, 3, 3);
      for (int i = 0; i < 9; i++)
         if (i % 2) push_px(255, 0, 255); else push_px(0, 255, 0);
      setup(MODE_SOFTEN, 127, 0, 2);
      push_px(255, 255, 255); push_px(0, 0, 0); push_px(0, 0, 0); push_px(255, 255, 255);
      setup(MODE_EMBOSS, 50, 4, 1);
      push_px(255, 255, 255); push_px(0, 0, 0); push_random(6);
      setup(MODE_SOFTEN, 0, 2048, 2048);
      push_random(3);
      setup(MODE_SHARPEN, 1, 3, 4095);
      push_random(6);

      sent = 0; phase = 0; w = 3; h = 4095;
      while (sent < 210) begin
         wait_drained();
         quiet = ($urandom_range(0, 3) == 0);
         write_reg(REG_MODE, 12'($urandom_range(0, 3)));
         write_reg(REG_STRENGTH, 12'($urandom_range(0, 127)));
         if (phase == 0 || $urandom_range(0, 9) < 7) begin
            w = $urandom_range(2, 8);
            h = $urandom_range(2, 6);
            write_reg(REG_WIDTH, 12'(w));
            write_reg(REG_HEIGHT, 12'(h));
         end
         if (phase == 2) begin
            quiet = 1;
            n = 3 * w * h;
            push_random(n);
            hold_seq++;
         end else begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w * h)
                                             : w * h * $urandom_range(1, 2);
            push_random(n);
         end
         sent += n;
         phase++;
      end

      do @(posedge clock);
      while (pixel_q.size() != 0 || req_valid || filtered_q.size() != 0);
      repeat (300) @(posedge clock);
      if (filtered_q.size() != 0) errors++;
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
